FILE: design/sdcd_pkg.sv
`timescale 1ns / 1ps
package sdcd_pkg;

	localparam int KHZ_W  = 20;
	localparam int MHZ_W  = 8;
	localparam int BASE_W = 18;
	localparam int CODE_W = 10;
	localparam int DIVQ_W = BASE_W;  // dividend / quotient width of a divider row
	localparam int DEN_W  = KHZ_W;   // divisor width of a divider row

	localparam int NUM_DIV_CELLS = DIVQ_W;

	localparam logic [MHZ_W-1:0]  BASE_MHZ_RST = 8'd200;
	localparam logic [BASE_W-1:0] KHZ_PER_MHZ  = 18'd1000;
	localparam logic [DIVQ_W-1:0] MAX_DIV      = 18'd2046;
	localparam logic [CODE_W-1:0] CODE_MAX     = 10'd1023;
	localparam logic [BASE_W-1:0] HS_LIMIT_KHZ = 18'd20000;
	localparam logic [BASE_W-1:0] DDR50_MAX    = 18'd52000;
	localparam logic [BASE_W-1:0] SDR12_MAX    = 18'd25000;
	localparam logic [BASE_W-1:0] SDR25_MAX    = 18'd50000;
	localparam logic [BASE_W-1:0] SDR50_MAX    = 18'd100000;

	typedef enum logic [2:0] {
		TM_KEEP   = 3'd0,
		TM_SDR12  = 3'd1,
		TM_SDR25  = 3'd2,
		TM_SDR50  = 3'd3,
		TM_SDR104 = 3'd4,
		TM_DDR50  = 3'd5,
		TM_HS400  = 3'd6
	} tm_t;

	// partial state of one restoring division, handed cell to cell
	typedef struct packed {
		logic [DEN_W-1:0]  rem;
		logic [DIVQ_W-1:0] num;  // dividend, MSB next to enter
		logic [DEN_W-1:0]  den;
		logic [DIVQ_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic              ddr;
		logic              bypass;
		logic              zero;
		logic [BASE_W-1:0] base;
	} side_a_t;

	typedef struct packed {
		logic              ddr;
		logic              bypass;
		logic              ovf;
		logic [CODE_W-1:0] code;
		logic [BASE_W-1:0] base;
	} side_b_t;

endpackage

FILE: design/sdcd_div_cell.sv
`timescale 1ns / 1ps
module sdcd_div_cell import sdcd_pkg::*; #(
	parameter int SIDE_W = $bits(side_a_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  div_t              in_div,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output div_t              out_div,
	output logic [SIDE_W-1:0] out_side
);

	logic              valid_q;
	div_t              div_q;
	logic [SIDE_W-1:0] side_q;
	logic [DEN_W:0]    trial;
	logic              fits;
	div_t              div_nx;

	assign in_ready = !valid_q || out_ready;

	// one quotient bit: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial  = {in_div.rem, in_div.num[DIVQ_W-1]};
		fits   = trial >= {1'b0, in_div.den};
		div_nx = in_div;
		div_nx.num = {in_div.num[DIVQ_W-2:0], 1'b0};
		div_nx.quo = {in_div.quo[DIVQ_W-2:0], fits};
		if (fits) begin
			div_nx.rem = DEN_W'(trial - {1'b0, in_div.den});
		end else begin
			div_nx.rem = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_q  <= div_nx;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

endmodule

FILE: design/sdcd_div_chain.sv
`timescale 1ns / 1ps
module sdcd_div_chain import sdcd_pkg::*; #(
	parameter int N_CELLS = NUM_DIV_CELLS,
	parameter int SIDE_W  = $bits(side_a_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  div_t              in_div,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output div_t              out_div,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld [N_CELLS+1];
	logic              rdy [N_CELLS+1];
	div_t              dv  [N_CELLS+1];
	logic [SIDE_W-1:0] sd  [N_CELLS+1];

	assign vld[0]       = in_valid;
	assign dv[0]        = in_div;
	assign sd[0]        = in_side;
	assign in_ready     = rdy[0];
	assign rdy[N_CELLS] = out_ready;
	assign out_valid    = vld[N_CELLS];
	assign out_div      = dv[N_CELLS];
	assign out_side     = sd[N_CELLS];

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		sdcd_div_cell #(.SIDE_W(SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[i]),
			.in_ready (rdy[i]),
			.in_div   (dv[i]),
			.in_side  (sd[i]),
			.out_valid(vld[i+1]),
			.out_ready(rdy[i+1]),
			.out_div  (dv[i+1]),
			.out_side (sd[i+1])
		);
	end

endmodule

FILE: design/sd_clock_divider_select_top.sv
`timescale 1ns / 1ps
// channel   | signals                           | payload
// ----------+-----------------------------------+----------------------------------------
// request   | s_tvalid s_tready s_tdata[23:0]   | target_khz, double_rate
// result    | m_tvalid m_tready m_tdata[39:0]   | divider_code, actual_khz, high_speed,
//           |                                   | bus_mode, divider_overflow
// config    | cfg_we cfg_wdata[7:0]             | base_clock_mhz
//
// One beat accepted per cycle unless the output stalls. Stages: prep stage, an 18-cell
// ceiling-ratio divider row, code stage, an 18-cell clock divider row, output register.
// Each cell resolves one quotient bit of a restoring division.
// Reset clears all valid bits and loads base_clock_mhz with 200.
// A stalled result holds in the output register; cells behind it keep moving
// until they fill, so bubbles collapse.
module sd_clock_divider_select_top import sdcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [19:0] target_khz, [20] double_rate, [23:21] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [9:0] divider_code, [27:10] actual_khz, [28] high_speed,
	                               // [31:29] bus_mode, [32] divider_overflow, [39:33] zero
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic [MHZ_W-1:0] base_mhz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_mhz_q <= BASE_MHZ_RST;
		end else if (cfg_we) begin
			base_mhz_q <= cfg_wdata;
		end
	end

	// ---- prep stage
	logic              v_s1, rdy_s1, rdy_a;
	logic [KHZ_W-1:0]  khz_s1;
	side_a_t           side_s1;
	logic [KHZ_W-1:0]  khz_in;
	logic [BASE_W-1:0] base_in;
	logic              byp_in;

	assign khz_in  = s_tdata[KHZ_W-1:0];
	assign base_in = BASE_W'(BASE_W'(base_mhz_q) * KHZ_PER_MHZ);
	assign byp_in  = khz_in >= KHZ_W'(base_in);
	assign rdy_s1  = !v_s1 || rdy_a;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			khz_s1         <= khz_in;
			side_s1.ddr    <= s_tdata[KHZ_W];
			side_s1.bypass <= byp_in;
			side_s1.zero   <= (khz_in == '0) && !byp_in;
			side_s1.base   <= base_in;
		end
	end

	// ---- ceiling ratio: (base - 1) / khz
	div_t    div_a_in, div_a_out;
	side_a_t side_a_out;
	logic    v_a, rdy_s2;

	always_comb begin
		div_a_in     = '0;
		div_a_in.num = side_s1.base - 1'b1;
		div_a_in.den = khz_s1;
	end

	sdcd_div_chain #(.N_CELLS(NUM_DIV_CELLS), .SIDE_W($bits(side_a_t))) u_chain_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_ready (rdy_a),
		.in_div   (div_a_in),
		.in_side  (side_s1),
		.out_valid(v_a),
		.out_ready(rdy_s2),
		.out_div  (div_a_out),
		.out_side (side_a_out)
	);

	// ---- code stage
	logic              v_s2, rdy_b;
	side_b_t           side_s2;
	logic              ovf_c;
	logic [11:0]       divisor_c;
	logic [11:0]       rnd_c;
	logic [CODE_W-1:0] code_c;

	always_comb begin
		ovf_c = !side_a_out.bypass && (side_a_out.zero || div_a_out.quo >= MAX_DIV);
		if (ovf_c) begin
			divisor_c = 12'(MAX_DIV);
		end else begin
			divisor_c = 12'(div_a_out.quo[10:0]) + 12'd1;
		end
		rnd_c  = divisor_c + 12'd1;  // round up to even, halve
		code_c = side_a_out.bypass ? '0 : rnd_c[CODE_W:1];
	end

	assign rdy_s2 = !v_s2 || rdy_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_a) begin
			side_s2.ddr    <= side_a_out.ddr;
			side_s2.bypass <= side_a_out.bypass;
			side_s2.ovf    <= ovf_c;
			side_s2.code   <= code_c;
			side_s2.base   <= side_a_out.base;
		end
	end

	// ---- actual clock: base / (2 * code)
	div_t    div_b_in, div_b_out;
	side_b_t side_b_out;
	logic    v_b, rdy_out;

	always_comb begin
		div_b_in     = '0;
		div_b_in.num = side_s2.base;
		div_b_in.den = DEN_W'({side_s2.code, 1'b0});
	end

	sdcd_div_chain #(.N_CELLS(NUM_DIV_CELLS), .SIDE_W($bits(side_b_t))) u_chain_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.in_ready (rdy_b),
		.in_div   (div_b_in),
		.in_side  (side_s2),
		.out_valid(v_b),
		.out_ready(rdy_out),
		.out_div  (div_b_out),
		.out_side (side_b_out)
	);

	// ---- output register
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;
	logic [BASE_W-1:0] actual_c;
	logic              hs_c;
	tm_t               tm_c;

	always_comb begin
		actual_c = side_b_out.bypass ? side_b_out.base : div_b_out.quo;
		hs_c     = actual_c > HS_LIMIT_KHZ;
		if (!hs_c) begin
			tm_c = TM_KEEP;
		end else if (side_b_out.ddr) begin
			tm_c = (actual_c <= DDR50_MAX) ? TM_DDR50 : TM_HS400;
		end else begin
			priority if (actual_c <= SDR12_MAX) tm_c = TM_SDR12;
			else if (actual_c <= SDR25_MAX) tm_c = TM_SDR25;
			else if (actual_c <= SDR50_MAX) tm_c = TM_SDR50;
			else tm_c = TM_SDR104;
		end
	end

	assign rdy_out = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (rdy_out) begin
			m_tvalid_q <= v_b;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_b) begin
			m_tdata_q <= {7'd0, side_b_out.ovf, tm_c, hs_c, actual_c, side_b_out.code};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: design/sdcd_checker.sv
`timescale 1ns / 1ps
module sdcd_checker import sdcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic [CODE_W-1:0] code;
	logic [BASE_W-1:0] actual;
	logic              hs;
	logic [2:0]        mode;
	logic              ovf;

	assign code   = m_tdata[9:0];
	assign actual = m_tdata[27:10];
	assign hs     = m_tdata[28];
	assign mode   = m_tdata[31:29];
	assign ovf    = m_tdata[32];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_hs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hs == (actual > HS_LIMIT_KHZ)) && (hs == (mode != TM_KEEP)))
		else $error("high-speed flag or bus mode inconsistent with clock");

	a_ovf_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ovf |-> code == CODE_MAX)
		else $error("overflow without clamped code");

	a_undivided: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code == '0 |-> !ovf)
		else $error("undivided clock flagged as overflow");

endmodule

bind sd_clock_divider_select_top sdcd_checker u_sdcd_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	import sdcd_pkg::*;

	localparam int PIPE_LATENCY   = 39;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_BEATS    = 250;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [BASE_W-1:0] actual_khz;
		logic              high_speed;
		tm_t               mode;
		logic              overflow;
	} clk_pick_t;

	typedef struct packed {
		logic [KHZ_W-1:0] khz;
		logic             ddr;
		logic             typed;
		clk_pick_t        want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	logic [MHZ_W-1:0] base_mhz = BASE_MHZ_RST;  // shadow of the base clock register
	logic             steady_run = 1'b0;        // no idling on either side
	clk_pick_t        pending_clocks[$];
	dir_row_t         directed_rows[$];
	int               errors = 0;
	int               n_requests = 0;
	int               n_results = 0;
	int               n_overflow = 0;
	int               n_settings = 1;
	int               stall_cycles = 0;

	always #10 clk = ~clk;

	sd_clock_divider_select_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [19:0] target_khz, [20] double_rate, [23:21] zero
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [9:0] code, [27:10] actual_khz, [28] high_speed,
		                        // [31:29] bus_mode, [32] divider_overflow
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	function automatic clk_pick_t predict_clock(input logic [MHZ_W-1:0] mhz,
	                                            input logic [KHZ_W-1:0] khz, input logic ddr);
		clk_pick_t   r;
		int unsigned base;
		int unsigned target;
		int unsigned div;
		int unsigned act;
		r = '0;
		base = int'(mhz) * 1000;
		target = int'(khz);
		if (target >= base) begin
			r.code = '0;
			act = base;
		end else begin
			if (target == 0) begin
				div = MAX_DIV;
				r.overflow = 1'b1;
			end else begin
				div = (base + target - 1) / target;
				if (div > MAX_DIV) begin
					div = MAX_DIV;
					r.overflow = 1'b1;
				end
			end
			// round up to an even divisor
			r.code = CODE_W'((div + 1) >> 1);
			act = base / ((div + 1) & ~32'd1);
		end
		r.actual_khz = BASE_W'(act);
		r.high_speed = act > HS_LIMIT_KHZ;
		if (!r.high_speed)
			r.mode = TM_KEEP;
		else if (ddr)
			r.mode = act <= DDR50_MAX ? TM_DDR50 : TM_HS400;
		else if (act <= SDR12_MAX)
			r.mode = TM_SDR12;
		else if (act <= SDR25_MAX)
			r.mode = TM_SDR25;
		else if (act <= SDR50_MAX)
			r.mode = TM_SDR50;
		else
			r.mode = TM_SDR104;
		return r;
	endfunction

	// targets near divisor steps and bus-mode edges, plus noise
	function automatic logic [KHZ_W-1:0] pick_target(input logic [MHZ_W-1:0] mhz);
		int t;
		int k;
		case ($urandom_range(0, 9))
			0: t = $urandom & 32'hfffff;
			1: t = $urandom_range(0, 3000);
			2: t = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 200);
			3: begin
				case ($urandom_range(0, 4))
					0: t = HS_LIMIT_KHZ;
					1: t = SDR12_MAX;
					2: t = SDR25_MAX;
					3: t = DDR50_MAX;
					default: t = SDR50_MAX;
				endcase
				t = t + $urandom_range(0, 6) - 3;
			end
			4: t = int'(mhz) * 1000 + $urandom_range(0, 4) - 2;
			default: begin
				k = $urandom_range(1, 2100);
				t = int'(mhz) * 1000 / k + $urandom_range(0, 4) - 2;
			end
		endcase
		if (t < 0)
			t = 0;
		if (t > 32'hfffff)
			t = 32'hfffff;
		return KHZ_W'(t);
	endfunction

	task automatic send_request(input logic [KHZ_W-1:0] khz, input logic ddr,
	                            input logic typed, input clk_pick_t want);
		if (!steady_run)
			while ($urandom_range(0, 99) < 19) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, ddr, khz};
		do
			@(posedge clk);
		while (!s_tready);
		pending_clocks.push_back(typed ? want : predict_clock(base_mhz, khz, ddr));
		n_requests++;
	endtask

	task automatic wait_drained();
		while (pending_clocks.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_base(input logic [MHZ_W-1:0] mhz);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= mhz;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_mhz = mhz;
		n_settings++;
	endtask

	always @(posedge clk)
		m_tready <= steady_run || ($urandom_range(0, 99) >= 19);

	// result checker
	always @(posedge clk) begin
		clk_pick_t got;
		clk_pick_t exp_pick;
		if (arst_n && m_tvalid && m_tready) begin
			got.code = m_tdata[9:0];
			got.actual_khz = m_tdata[27:10];
			got.high_speed = m_tdata[28];
			got.mode = tm_t'(m_tdata[31:29]);
			got.overflow = m_tdata[32];
			if (pending_clocks.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, got %h", $time, m_tdata);
			end else begin
				exp_pick = pending_clocks.pop_front();
				n_results++;
				if (exp_pick.overflow)
					n_overflow++;
				if (got != exp_pick) begin
					errors++;
					if (got.code != exp_pick.code)
						$display("%0t: divider_code expected %0d got %0d",
							$time, exp_pick.code, got.code);
					if (got.actual_khz != exp_pick.actual_khz)
						$display("%0t: actual_khz expected %0d got %0d",
							$time, exp_pick.actual_khz, got.actual_khz);
					if (got.high_speed != exp_pick.high_speed)
						$display("%0t: high_speed expected %0d got %0d",
							$time, exp_pick.high_speed, got.high_speed);
					if (got.mode != exp_pick.mode)
						$display("%0t: bus_mode expected %0d got %0d",
							$time, exp_pick.mode, got.mode);
					if (got.overflow != exp_pick.overflow)
						$display("%0t: divider_overflow expected %0d got %0d",
							$time, exp_pick.overflow, got.overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk_pick_t   none;
		logic [7:0]  mhz;
		int          p;
		int          i;
		none = '0;

		// base clock at its reset value of 200 MHz for the directed rows
		directed_rows.push_back('{20'd200000, 1'b0, 1'b1,
			'{10'd0, 18'd200000, 1'b1, TM_SDR104, 1'b0}});
		directed_rows.push_back('{20'hfffff, 1'b1, 1'b1,
			'{10'd0, 18'd200000, 1'b1, TM_HS400, 1'b0}});
		directed_rows.push_back('{20'd0, 1'b0, 1'b1,
			'{10'd1023, 18'd97, 1'b0, TM_KEEP, 1'b1}});
		directed_rows.push_back('{20'd1, 1'b1, 1'b1,
			'{10'd1023, 18'd97, 1'b0, TM_KEEP, 1'b1}});
		directed_rows.push_back('{20'd100000, 1'b0, 1'b1,
			'{10'd1, 18'd100000, 1'b1, TM_SDR50, 1'b0}});
		directed_rows.push_back('{20'd100000, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd199999, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd200001, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd25000, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd50000, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd50000, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd52000, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd40000, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd66667, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd133334, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd20000, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd20001, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd97, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd98, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'd99999, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd524288, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'd1000000, 1'b1, 1'b0, none});
		directed_rows.push_back('{20'h55555, 1'b0, 1'b0, none});
		directed_rows.push_back('{20'haaaaa, 1'b1, 1'b0, none});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			send_request(directed_rows[r].khz, directed_rows[r].ddr,
				directed_rows[r].typed, directed_rows[r].want);
		s_tvalid <= 1'b0;

		for (p = 0; p < 8; p++) begin
			case (p)
				0: mhz = 8'd255;
				1: mhz = 8'd0;
				2: mhz = 8'd1;
				3: mhz = BASE_MHZ_RST;
				default: mhz = 8'($urandom_range(0, 255));
			endcase
			// pause the sender until everything in flight has come back
			write_base(mhz);
			steady_run <= (p == 3);
			for (i = 0; i < PHASE_BEATS; i++)
				send_request(pick_target(base_mhz), 1'($urandom), 1'b0, none);
			s_tvalid <= 1'b0;
		end
		steady_run <= 1'b0;

		wait_drained();
		$display("Sent %0d requests under %0d base clock settings; checked %0d results",
			n_requests, n_settings, n_results);
		$display("%0d results hit the divisor clamp", n_overflow);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
